// ===== src/wsp_pkg.sv =====
// Shared constants and types for the world-to-screen projection pipeline.
`default_nettype none

package wsp_pkg;

    // Default fractional bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    // Quotient bits resolved by the divider, and steps per divider stage
    localparam int QBITS      = 33;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = QBITS / DIV_STEPS;
    // Pre stage + iteration stages + post stage
    localparam int DIV_LAT    = DIV_STAGES + 2;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;

    // Matrix select codes
    localparam logic SEL_VIEW = 1'b0;
    localparam logic SEL_PROJ = 1'b1;

    // Side information that travels with every item
    typedef struct packed {
        logic               load;
        logic               msel;
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic               fault;
    } tag_t;

endpackage

`default_nettype wire

// ===== src/wsp_div.sv =====
// Pipelined signed fixed-point divider (n << FRAC_BITS) / w with saturation.
`default_nettype none

module wsp_div #(
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               adv,
    input  wire logic signed [31:0] n,
    input  wire logic signed [31:0] w,
    output logic signed [31:0]      q,
    output logic                    fault
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int HW = DW - wsp_pkg::QBITS;
    localparam int NS = wsp_pkg::DIV_STAGES;
    localparam int QB = wsp_pkg::QBITS;

    logic [31:0]   nm;
    logic [31:0]   wmag;
    logic [DW-1:0] dvd;
    logic [HW-1:0] hi;

    logic [31:0]   rem_reg  [NS+1];
    logic [QB-1:0] low_reg  [NS+1];
    logic [QB-1:0] quo_reg  [NS+1];
    logic [31:0]   wm_reg   [NS+1];
    logic          neg_reg  [NS+1];
    logic          npos_reg [NS+1];
    logic          nneg_reg [NS+1];
    logic          wz_reg   [NS+1];
    logic          ovf_reg  [NS+1];

    logic [QB-1:0]      qf;
    logic signed [31:0] q_next;

    // Split operands into sign and magnitude
    assign nm   = n[31] ? (~n + 32'd1) : n;
    assign wmag = w[31] ? (~w + 32'd1) : w;
    assign dvd  = {nm, {FRAC_BITS{1'b0}}};
    assign hi   = dvd[DW-1:QB];

    // Pre stage: load the long division
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= 32'(hi);
            low_reg[0]  <= dvd[QB-1:0];
            quo_reg[0]  <= '0;
            wm_reg[0]   <= wmag;
            neg_reg[0]  <= n[31] ^ w[31];
            npos_reg[0] <= !n[31] && (n != 32'sd0);
            nneg_reg[0] <= n[31];
            wz_reg[0]   <= (w == 32'sd0);
            ovf_reg[0]  <= (32'(hi) >= wmag);
        end
    end

    // Iteration stages: DIV_STEPS restoring steps each
    for (genvar k = 0; k < NS; k++)
    begin : g_iter
        logic [31:0]   r_c;
        logic [QB-1:0] l_c;
        logic [QB-1:0] q_c;

        always_comb
        begin
            logic [32:0] t;
            r_c = rem_reg[k];
            l_c = low_reg[k];
            q_c = quo_reg[k];
            for (int s = 0; s < wsp_pkg::DIV_STEPS; s++)
            begin
                t   = {r_c, l_c[QB-1]};
                l_c = {l_c[QB-2:0], 1'b0};
                if (t >= {1'b0, wm_reg[k]})
                begin
                    t   = t - {1'b0, wm_reg[k]};
                    q_c = {q_c[QB-2:0], 1'b1};
                end
                else
                begin
                    q_c = {q_c[QB-2:0], 1'b0};
                end
                r_c = t[31:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1]  <= r_c;
                low_reg[k+1]  <= l_c;
                quo_reg[k+1]  <= q_c;
                wm_reg[k+1]   <= wm_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                npos_reg[k+1] <= npos_reg[k];
                nneg_reg[k+1] <= nneg_reg[k];
                wz_reg[k+1]   <= wz_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
            end
        end
    end

    // Post stage: apply sign and saturate
    assign qf = quo_reg[NS];

    always_comb
    begin
        if (wz_reg[NS])
        begin
            if (npos_reg[NS])
                q_next = wsp_pkg::S32_MAX;
            else if (nneg_reg[NS])
                q_next = wsp_pkg::S32_MIN;
            else
                q_next = 32'sd0;
        end
        else if (ovf_reg[NS])
        begin
            q_next = neg_reg[NS] ? wsp_pkg::S32_MIN : wsp_pkg::S32_MAX;
        end
        else if (neg_reg[NS])
        begin
            if (qf > 33'h0_8000_0000)
                q_next = wsp_pkg::S32_MIN;
            else
                q_next = ~qf[31:0] + 32'd1;
        end
        else
        begin
            if (qf > 33'h0_7FFF_FFFF)
                q_next = wsp_pkg::S32_MAX;
            else
                q_next = qf[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q     <= q_next;
            fault <= wz_reg[NS];
        end
    end

endmodule

`default_nettype wire

// ===== src/wsp_xform.sv =====
// One homogeneous transform: matrix storage, multiply, sum and divide by w.
`default_nettype none

module wsp_xform #(
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               this_sel,
    input  wire logic               in_valid,
    input  wire wsp_pkg::tag_t      in_tag,
    input  wire logic signed [31:0] in_x,
    input  wire logic signed [31:0] in_y,
    input  wire logic signed [31:0] in_z,
    output logic                    out_valid,
    output wsp_pkg::tag_t           out_tag,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z
);

    localparam int PW  = 64 - FRAC_BITS;
    localparam int SW  = PW + 2;
    localparam int LAT = wsp_pkg::DIV_LAT;
    localparam logic signed [31:0] ONE = 32'(1) << FRAC_BITS;

    logic signed [31:0] m_reg [16];
    logic signed [31:0] pin [3];
    logic signed [63:0] prod_full [3][4];

    logic signed [PW-1:0] prod_reg [3][4];
    logic signed [31:0]   bias_reg [4];
    logic                 a_valid_reg;
    wsp_pkg::tag_t        a_tag_reg;

    logic signed [31:0]   r_next [4];
    logic signed [31:0]   r_reg  [4];
    logic                 b_valid_reg;
    wsp_pkg::tag_t        b_tag_reg;

    logic                 dly_valid_reg [LAT];
    wsp_pkg::tag_t        dly_tag_reg   [LAT];

    logic signed [31:0]   q [3];
    logic                 wfault;
    logic                 wfault_y;
    logic                 wfault_z;

    assign pin[0] = in_x;
    assign pin[1] = in_y;
    assign pin[2] = in_z;

    // Hold the matrix; a load writes when it passes the multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                m_reg[i] <= (i % 5 == 0) ? ONE : 32'sd0;
        end
        else if (adv && in_valid && in_tag.load && (in_tag.msel == this_sel))
        begin
            m_reg[in_tag.idx] <= in_tag.val;
        end
    end

    // Form every product of the point with the upper three rows
    for (genvar i = 0; i < 3; i++)
    begin : g_row
        for (genvar j = 0; j < 4; j++)
        begin : g_col
            assign prod_full[i][j] = pin[i] * m_reg[i*4+j];
        end
    end

    // Stage A: floored products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 4; j++)
                    prod_reg[i][j] <= prod_full[i][j][63:FRAC_BITS];
            for (int j = 0; j < 4; j++)
                bias_reg[j] <= m_reg[12+j];
            a_tag_reg <= in_tag;
        end
    end

    // Stage B: sum each column and saturate
    always_comb
    begin
        logic signed [SW-1:0] s;
        for (int j = 0; j < 4; j++)
        begin
            s = SW'(prod_reg[0][j]) + SW'(prod_reg[1][j]) + SW'(prod_reg[2][j])
                + SW'(bias_reg[j]);
            if (s[SW-1:31] != {(SW-31){s[31]}})
                r_next[j] = s[SW-1] ? wsp_pkg::S32_MIN : wsp_pkg::S32_MAX;
            else
                r_next[j] = s[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
                r_reg[j] <= r_next[j];
            b_tag_reg <= a_tag_reg;
        end
    end

    // Carry side information alongside the dividers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dly_tag_reg[0] <= b_tag_reg;
            for (int k = 1; k < LAT; k++)
                dly_tag_reg[k] <= dly_tag_reg[k-1];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            for (int k = 0; k < LAT; k++)
                dly_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg      <= in_valid;
            b_valid_reg      <= a_valid_reg;
            dly_valid_reg[0] <= b_valid_reg;
            for (int k = 1; k < LAT; k++)
                dly_valid_reg[k] <= dly_valid_reg[k-1];
        end
    end

    // Divide x, y and z by w
    wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk(clk), .adv(adv), .n(r_reg[0]), .w(r_reg[3]), .q(q[0]), .fault(wfault)
    );
    wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk(clk), .adv(adv), .n(r_reg[1]), .w(r_reg[3]), .q(q[1]), .fault(wfault_y)
    );
    wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
        .clk(clk), .adv(adv), .n(r_reg[2]), .w(r_reg[3]), .q(q[2]), .fault(wfault_z)
    );

    always_comb
    begin
        out_tag       = dly_tag_reg[LAT-1];
        out_tag.fault = dly_tag_reg[LAT-1].fault | wfault | wfault_y | wfault_z;
    end

    assign out_valid = dly_valid_reg[LAT-1];
    assign out_x     = q[0];
    assign out_y     = q[1];
    assign out_z     = q[2];

endmodule

`default_nettype wire

// ===== src/world_to_screen_projection_top.sv =====
// Top level of the world-to-screen point projection pipeline.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid/in_ready   | kind, matrix_select, entry_index,
//          |                     | entry_value, point_x, point_y, point_z
//  out     | out_valid/out_ready | visible, screen_x, screen_y, screen_depth,
//          |                     | divide_fault
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item enters per cycle unless the pipe holds. A project item passes the input
// stage, two transforms of 15 stages each (multiply, sum, 13-stage divider doing
// three quotient bits per iteration stage), and two viewport stages. Loads flow
// down the pipe and write their matrix at that transform's multiply stage, so they
// order correctly against points. The whole pipe holds while the output register
// holds an item not yet taken. Reset clears valid bits and the offset, sets width
// 1280, height 720 and both matrices to identity. cfg_ready is always high.
`default_nettype none

module world_to_screen_projection_top #(
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    input  wire logic               matrix_select,
    input  wire logic [3:0]         entry_index,
    input  wire logic signed [31:0] entry_value,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    visible,
    output logic signed [31:0]      screen_x,
    output logic signed [31:0]      screen_y,
    output logic signed [31:0]      screen_depth,
    output logic                    divide_fault,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    localparam logic signed [32:0] ONE33 = 33'(1) << FRAC_BITS;

    logic               adv;
    logic [13:0]        width_reg;
    logic [13:0]        height_reg;
    logic signed [31:0] offset_reg;

    logic signed [32:0] ysum;
    logic signed [31:0] ysat;

    logic               s0_valid_reg;
    wsp_pkg::tag_t      s0_tag_reg;
    logic signed [31:0] s0_x_reg;
    logic signed [31:0] s0_y_reg;
    logic signed [31:0] s0_z_reg;

    logic               x0_valid;
    wsp_pkg::tag_t      x0_tag;
    logic signed [31:0] x0_x, x0_y, x0_z;
    logic               x1_valid;
    wsp_pkg::tag_t      x1_tag;
    logic signed [31:0] x1_x, x1_y, x1_z;

    logic signed [32:0] xs;
    logic signed [32:0] ys;
    logic signed [47:0] sxp_next;
    logic signed [47:0] syp_next;

    logic               f1_valid_reg;
    logic signed [47:0] f1_sxp_reg;
    logic signed [47:0] f1_syp_reg;
    logic signed [31:0] f1_nz_reg;
    logic               f1_vis_reg;
    logic               f1_fault_reg;

    logic [46:0]        hx;
    logic [46:0]        hy;
    logic signed [31:0] sx_next;
    logic signed [31:0] sy_next;

    // Advance the whole pipe unless the output item waits
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 14'd1280;
            height_reg <= 14'd720;
            offset_reg <= 32'sd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wsp_pkg::REG_WIDTH:  width_reg  <= cfg_data[13:0];
                wsp_pkg::REG_HEIGHT: height_reg <= cfg_data[13:0];
                wsp_pkg::REG_OFFSET: offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Add the height offset with saturation
    assign ysum = {point_y[31], point_y} + {offset_reg[31], offset_reg};
    assign ysat = (ysum[32] != ysum[31])
                ? (ysum[32] ? wsp_pkg::S32_MIN : wsp_pkg::S32_MAX) : ysum[31:0];

    // Input stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_tag_reg.load  <= !kind;
            s0_tag_reg.msel  <= matrix_select;
            s0_tag_reg.idx   <= entry_index;
            s0_tag_reg.val   <= entry_value;
            s0_tag_reg.fault <= 1'b0;
            s0_x_reg         <= point_x;
            s0_y_reg         <= ysat;
            s0_z_reg         <= point_z;
        end
    end

    wsp_xform #(.FRAC_BITS(FRAC_BITS)) u_view (
        .clk(clk), .rst_n(rst_n), .adv(adv), .this_sel(wsp_pkg::SEL_VIEW),
        .in_valid(s0_valid_reg), .in_tag(s0_tag_reg),
        .in_x(s0_x_reg), .in_y(s0_y_reg), .in_z(s0_z_reg),
        .out_valid(x0_valid), .out_tag(x0_tag),
        .out_x(x0_x), .out_y(x0_y), .out_z(x0_z)
    );

    wsp_xform #(.FRAC_BITS(FRAC_BITS)) u_proj (
        .clk(clk), .rst_n(rst_n), .adv(adv), .this_sel(wsp_pkg::SEL_PROJ),
        .in_valid(x0_valid), .in_tag(x0_tag),
        .in_x(x0_x), .in_y(x0_y), .in_z(x0_z),
        .out_valid(x1_valid), .out_tag(x1_tag),
        .out_x(x1_x), .out_y(x1_y), .out_z(x1_z)
    );

    // Viewport stage 1: scale by the screen size, test depth
    assign xs       = {x1_x[31], x1_x} + ONE33;
    assign ys       = ONE33 - {x1_y[31], x1_y};
    assign sxp_next = xs * $signed({1'b0, width_reg});
    assign syp_next = ys * $signed({1'b0, height_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_sxp_reg   <= sxp_next;
            f1_syp_reg   <= syp_next;
            f1_nz_reg    <= x1_z;
            f1_vis_reg   <= !x1_z[31] && ({x1_z[31], x1_z} <= ONE33);
            f1_fault_reg <= x1_tag.fault;
        end
    end

    // Viewport stage 2: halve, saturate, zero when not visible
    assign hx = f1_sxp_reg[47:1];
    assign hy = f1_syp_reg[47:1];
    assign sx_next = (hx[46:31] != {16{hx[31]}})
                   ? (hx[46] ? wsp_pkg::S32_MIN : wsp_pkg::S32_MAX) : hx[31:0];
    assign sy_next = (hy[46:31] != {16{hy[31]}})
                   ? (hy[46] ? wsp_pkg::S32_MIN : wsp_pkg::S32_MAX) : hy[31:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            visible      <= f1_vis_reg;
            screen_x     <= f1_vis_reg ? sx_next : 32'sd0;
            screen_y     <= f1_vis_reg ? sy_next : 32'sd0;
            screen_depth <= f1_vis_reg ? f1_nz_reg : 32'sd0;
            divide_fault <= f1_vis_reg && f1_fault_reg;
        end
    end

    // Advance valid bits; drop loads before the viewport stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
            f1_valid_reg <= x1_valid && !x1_tag.load;
            out_valid    <= f1_valid_reg;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the world-to-screen point projection pipeline.
`timescale 1ns / 1ps

module tb_top;

    localparam int FB       = 16;
    localparam longint ONE  = 64'sd1 << FB;
    localparam int PIPE_LAT = 40;
    localparam longint LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic matrix_select = 1'b0;
    logic [3:0] entry_index = '0;
    logic signed [31:0] entry_value = '0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic signed [31:0] point_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] screen_depth;
    logic divide_fault;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    typedef struct packed {
        logic               vis;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sd;
        logic               flt;
    } screen_pt_t;

    screen_pt_t pending_pts[$];
    logic signed [31:0] view_m[16];
    logic signed [31:0] proj_m[16];
    logic [13:0] vp_width;
    logic [13:0] vp_height;
    logic signed [31:0] y_offset;
    int errors = 0;
    int points_sent = 0;
    int loads_sent = 0;
    int points_seen = 0;
    int visible_seen = 0;
    int faults_seen = 0;
    longint cycles = 0;
    bit idle_mode = 1'b1;

    world_to_screen_projection_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .matrix_select(matrix_select), .entry_index(entry_index),
        .entry_value(entry_value), .point_x(point_x), .point_y(point_y),
        .point_z(point_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .visible(visible), .screen_x(screen_x), .screen_y(screen_y),
        .screen_depth(screen_depth), .divide_fault(divide_fault),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sh7FFF_FFFF)
            return wsp_pkg::S32_MAX;
        if (v < -64'sh8000_0000)
            return wsp_pkg::S32_MIN;
        return v[31:0];
    endfunction

    // Floor shift of a signed value
    function automatic longint floor_shr(longint p, int s);
        return p >>> s;
    endfunction

    function automatic logic signed [31:0] fixed_div(logic signed [31:0] n,
                                                     logic signed [31:0] w,
                                                     ref bit flt);
        longint q;
        if (w == 0)
        begin
            flt = 1'b1;
            return (n > 0) ? wsp_pkg::S32_MAX : ((n < 0) ? wsp_pkg::S32_MIN : 32'sd0);
        end
        q = (longint'(n) * ONE) / longint'(w);
        return sat32(q);
    endfunction

    // Row vector (p,1) times matrix, then divide by w
    task automatic apply_matrix(input logic signed [31:0] m[16],
                                inout logic signed [31:0] p[3], inout bit flt);
        logic signed [31:0] r[4];
        longint acc;
        for (int j = 0; j < 4; j++)
        begin
            acc = longint'(m[12 + j]);
            for (int i = 0; i < 3; i++)
                acc += floor_shr(longint'(p[i]) * longint'(m[i * 4 + j]), FB);
            r[j] = sat32(acc);
        end
        for (int j = 0; j < 3; j++)
            p[j] = fixed_div(r[j], r[3], flt);
    endtask

    task automatic project_point(input logic signed [31:0] x, y, z,
                                 output screen_pt_t res);
        logic signed [31:0] p[3];
        bit flt;
        flt = 1'b0;
        p[0] = x;
        p[1] = sat32(longint'(y) + longint'(y_offset));
        p[2] = z;
        apply_matrix(view_m, p, flt);
        apply_matrix(proj_m, p, flt);
        res = '0;
        if (p[2] < 0 || longint'(p[2]) > ONE)
            return;
        res.vis = 1'b1;
        res.sx = sat32(floor_shr((longint'(p[0]) + ONE) * longint'(vp_width), 1));
        res.sy = sat32(floor_shr((ONE - longint'(p[1])) * longint'(vp_height), 1));
        res.sd = p[2];
        res.flt = flt;
    endtask

    function automatic void reset_matrices();
        for (int i = 0; i < 16; i++)
        begin
            view_m[i] = (i % 5 == 0) ? 32'sh0001_0000 : 32'sd0;
            proj_m[i] = (i % 5 == 0) ? 32'sh0001_0000 : 32'sd0;
        end
    endfunction

    function automatic int draw_gap();
        return idle_mode ? $urandom_range(0, 15) : 0;
    endfunction

    // Send one item and update the predicted state; valid stays high after
    // acceptance until the next falling edge, where it is dropped or reused
    task automatic send_item(input logic k, input logic ms, input logic [3:0] ix,
                             input logic signed [31:0] ev,
                             input logic signed [31:0] x, y, z);
        screen_pt_t res;
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind <= k;
        matrix_select <= ms;
        entry_index <= ix;
        entry_value <= ev;
        point_x <= x;
        point_y <= y;
        point_z <= z;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (k == 1'b0)
        begin
            if (ms == wsp_pkg::SEL_PROJ)
                proj_m[ix] = ev;
            else
                view_m[ix] = ev;
            loads_sent++;
        end
        else
        begin
            project_point(x, y, z, res);
            pending_pts.push_back(res);
            points_sent++;
        end
    endtask

    task automatic load_entry(input logic ms, input logic [3:0] ix,
                              input logic signed [31:0] ev);
        send_item(1'b0, ms, ix, ev, $urandom, $urandom, $urandom);
    endtask

    task automatic send_point(input logic signed [31:0] x, y, z);
        send_item(1'b1, 1'($urandom), 4'($urandom), $urandom, x, y, z);
    endtask

    // Drop valid, wait for all results, then let loads still in flight drain
    task automatic drain_pipe();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pts.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] ix, input logic [31:0] d);
        @(negedge clk);
        cfg_index <= ix;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (ix)
            wsp_pkg::REG_WIDTH:  vp_width = d[13:0];
            wsp_pkg::REG_HEIGHT: vp_height = d[13:0];
            wsp_pkg::REG_OFFSET: y_offset = d;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sink: random stall, then compare each result against the oldest prediction
    initial
    begin
        screen_pt_t exp_pt;
        int gap;
        forever
        begin
            @(negedge clk);
            gap = draw_gap();
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_pts.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d", $time, screen_x, screen_y);
                errors++;
            end
            else
            begin
                exp_pt = pending_pts.pop_front();
                points_seen++;
                if (visible) visible_seen++;
                if (divide_fault) faults_seen++;
                if (visible !== exp_pt.vis)
                begin
                    $display("%0t: visible exp %0d got %0d", $time, exp_pt.vis, visible);
                    errors++;
                end
                if (screen_x !== exp_pt.sx)
                begin
                    $display("%0t: screen_x exp %0d got %0d", $time, exp_pt.sx, screen_x);
                    errors++;
                end
                if (screen_y !== exp_pt.sy)
                begin
                    $display("%0t: screen_y exp %0d got %0d", $time, exp_pt.sy, screen_y);
                    errors++;
                end
                if (screen_depth !== exp_pt.sd)
                begin
                    $display("%0t: screen_depth exp %0d got %0d", $time, exp_pt.sd,
                             screen_depth);
                    errors++;
                end
                if (divide_fault !== exp_pt.flt)
                begin
                    $display("%0t: divide_fault exp %0d got %0d", $time, exp_pt.flt,
                             divide_fault);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_fx(int span);
        logic signed [31:0] v;
        v = $urandom_range(0, span);
        return ($urandom_range(0, 1) == 1) ? -v : v;
    endfunction

    // Extremes of the point fields through the identity transform
    task automatic test_extremes();
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(32'sh0000_8000, 32'sh0000_4000, 32'sh0001_0000);
        send_point(wsp_pkg::S32_MAX, wsp_pkg::S32_MIN, 32'sh0000_8000);
        send_point(wsp_pkg::S32_MIN, wsp_pkg::S32_MAX, 32'sh0000_0001);
        send_point(32'sh0000_1000, 32'sd0, -32'sd1);
        send_point(32'sh0000_1000, 32'sd0, 32'sh0001_0001);
        send_point(32'hFFFF_FFFF, 32'h5555_5555, wsp_pkg::S32_MAX);
        send_point(32'hAAAA_AAAA, 32'hFFFF_FFFF, wsp_pkg::S32_MIN);
    endtask

    // Zero w in the view stage and in the projection stage
    task automatic test_zero_w();
        load_entry(wsp_pkg::SEL_VIEW, 4'd15, 32'sd0);
        send_point(32'sh0000_2000, -32'sh0000_3000, 32'sd0);
        send_point(32'sd0, 32'sd0, 32'sd0);
        load_entry(wsp_pkg::SEL_VIEW, 4'd15, 32'sh0001_0000);
        load_entry(wsp_pkg::SEL_PROJ, 4'd15, 32'sd0);
        load_entry(wsp_pkg::SEL_PROJ, 4'd11, 32'sh0000_8000);
        send_point(32'sh0000_4000, 32'sh0000_4000, -32'sh0000_4000);
        send_point(32'sd0, 32'sd0, 32'sh0000_0100);
        load_entry(wsp_pkg::SEL_PROJ, 4'd15, 32'sh0001_0000);
        load_entry(wsp_pkg::SEL_PROJ, 4'd11, 32'sd0);
        load_entry(wsp_pkg::SEL_VIEW, 4'd0, wsp_pkg::S32_MIN);
        load_entry(wsp_pkg::SEL_VIEW, 4'd5, wsp_pkg::S32_MAX);
        send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0000_8000);
        reset_matrices_dut();
    endtask

    // Put both matrices back to identity through load items
    task automatic reset_matrices_dut();
        for (int m = 0; m < 2; m++)
            for (int i = 0; i < 16; i++)
                load_entry(m[0], i[3:0], (i % 5 == 0) ? 32'sh0001_0000 : 32'sd0);
    endtask

    // A phase of random items, mostly projections
    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 12)
                load_entry(1'($urandom), 4'($urandom), rand_fx(32'h0002_0000));
            else if (r < 15)
                load_entry(1'($urandom), 4'($urandom), $urandom);
            else if (r < 85)
                send_point(rand_fx(32'h0001_0000), rand_fx(32'h0001_0000),
                           $urandom_range(0, 32'h0001_0000));
            else
                send_point($urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_config(input logic [31:0] w, h, off);
        drain_pipe();
        write_reg(wsp_pkg::REG_WIDTH, w);
        write_reg(wsp_pkg::REG_HEIGHT, h);
        write_reg(wsp_pkg::REG_OFFSET, off);
    endtask

    initial
    begin
        vp_width = 14'd1280;
        vp_height = 14'd720;
        y_offset = '0;
        reset_matrices();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extremes();
        test_zero_w();
        test_config(32'd1, 32'd8192, 32'sh0000_8000);
        test_extremes();
        test_config(32'd0, 32'd0, wsp_pkg::S32_MAX);
        test_random(80);
        test_config(32'h3FFF, 32'h3FFF, wsp_pkg::S32_MIN);
        test_random(80);
        idle_mode = 1'b0;
        test_config(32'd1920, 32'd1080, 32'hFFFF_0000);
        test_random(150);
        idle_mode = 1'b1;
        test_random(150);
        test_config(32'd640, 32'd480, 32'd0);
        test_random(150);

        drain_pipe();
        $display("%0d points and %0d loads sent; %0d results checked, %0d visible, %0d faults",
                 points_sent, loads_sent, points_seen, visible_seen, faults_seen);
        $display("register settings included zero, minimum and maximum screen sizes");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
src/wsp_pkg.sv
src/wsp_div.sv
src/wsp_xform.sv
src/world_to_screen_projection_top.sv
tb/tb_top.sv
